// ===== rtl/vpnt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vpnt_pkg;

    localparam int CoefW = 16;
    localparam int VecW  = 32;
    localparam int ProdW = 48;
    localparam int DotW  = 50;
    localparam int MagW  = 30;
    localparam int SqW   = 62;
    localparam int LenW  = 31;
    localparam int NumW  = 47;
    localparam int QW    = 17;
    localparam int SqrtSteps = 31;
    localparam int DivSteps  = 17;

    localparam logic [2:0] REG_AFF_X  = 3'd0;
    localparam logic [2:0] REG_AFF_Y  = 3'd1;
    localparam logic [2:0] REG_AFF_Z  = 3'd2;
    localparam logic [2:0] REG_OFF_XY = 3'd3;
    localparam logic [2:0] REG_OFF_Z  = 3'd4;
    localparam logic [2:0] REG_NRM_X  = 3'd5;
    localparam logic [2:0] REG_NRM_Y  = 3'd6;
    localparam logic [2:0] REG_NRM_Z  = 3'd7;

    typedef logic [47:0] row_t;

    typedef struct packed {
        logic                     valid;
        logic                     kind;
        logic                     degenerate;
        logic [2:0]               neg;
        logic [2:0][MagW-1:0]     mag;
        logic signed [2:0][DotW-1:0] pos;
    } norm_in_t;

endpackage

`default_nettype wire

// ===== rtl/vpnt_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Normal path back end: square sum, root and per-component divide, one step a stage.
module vpnt_stage (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  wire vpnt_pkg::norm_in_t    din,
    output logic                       out_valid,
    output logic                       out_kind,
    output logic                       out_degenerate,
    output logic [2:0][31:0]           out_vec
);
    import vpnt_pkg::*;

    localparam int NS = 2 + SqrtSteps + 1 + DivSteps;

    typedef struct packed {
        logic                 valid;
        logic                 kind;
        logic                 degenerate;
        logic [2:0]           neg;
        logic [2:0][MagW-1:0] mag;
        logic [SqW+1:0]       rem;
        logic [SqW-1:0]       x;
        logic [LenW:0]        res;
        logic [2:0][NumW-1:0] num;
        logic [2:0][QW-1:0]   q;
        logic [2:0][31:0]     pos;
    } pipe_t;

    pipe_t st_reg [NS];
    pipe_t st_next [NS];

    always_comb
    begin
        logic [SqW-1:0]   sq;
        logic [SqW+1:0]   trial;
        logic [NumW:0]    sub;
        int               j;
        for (int s = 0; s < NS; s++)
        begin
            st_next[s] = (s == 0) ? '0 : st_reg[s-1];
        end
        // stage 0: load and square sum
        st_next[0].valid      = din.valid;
        st_next[0].kind       = din.kind;
        st_next[0].degenerate = din.degenerate;
        st_next[0].neg        = din.neg;
        st_next[0].mag        = din.mag;
        for (int k = 0; k < 3; k++)
        begin
            st_next[0].pos[k] = din.pos[k][31:0];
        end
        sq = '0;
        for (int k = 0; k < 3; k++)
        begin
            sq = sq + SqW'(64'(din.mag[k]) * 64'(din.mag[k]));
        end
        st_next[0].x = sq;
        // stage 1: clear root state
        st_next[1].rem = '0;
        st_next[1].res = '0;
        // root stages: one result bit each, restoring
        for (int s = 0; s < SqrtSteps; s++)
        begin
            j = 2 + s;
            st_next[j] = st_reg[j-1];
            trial = {st_reg[j-1].rem[SqW-1:0], st_reg[j-1].x[SqW-1 -: 2]};
            st_next[j].x = {st_reg[j-1].x[SqW-3:0], 2'b00};
            if (trial >= (SqW+2)'({st_reg[j-1].res, 2'b01}))
            begin
                st_next[j].rem = trial - (SqW+2)'({st_reg[j-1].res, 2'b01});
                st_next[j].res = {st_reg[j-1].res[LenW-1:0], 1'b1};
            end
            else
            begin
                st_next[j].rem = trial;
                st_next[j].res = {st_reg[j-1].res[LenW-1:0], 1'b0};
            end
        end
        // numerator setup
        j = 2 + SqrtSteps;
        st_next[j] = st_reg[j-1];
        for (int k = 0; k < 3; k++)
        begin
            st_next[j].num[k] = NumW'({st_reg[j-1].mag[k], 16'd0})
                              + NumW'(st_reg[j-1].res[LenW-1:1]);
            st_next[j].q[k]   = '0;
        end
        // divide stages: quotient below 2^17, one bit per stage
        for (int s = 0; s < DivSteps; s++)
        begin
            j = 3 + SqrtSteps + s;
            st_next[j] = st_reg[j-1];
            for (int k = 0; k < 3; k++)
            begin
                sub = {1'b0, st_reg[j-1].num[k]}
                    - ((NumW+1)'(st_reg[j-1].res[LenW-1:0]) << (DivSteps-1-s));
                if (!sub[NumW])
                begin
                    st_next[j].num[k] = sub[NumW-1:0];
                    st_next[j].q[k]   = st_reg[j-1].q[k] | (QW'(1) << (DivSteps-1-s));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
            begin
                st_reg[s] <= '0;
            end
        end
        else if (advance)
        begin
            for (int s = 0; s < NS; s++)
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    always_comb
    begin
        out_valid      = st_reg[NS-1].valid;
        out_kind       = st_reg[NS-1].kind;
        out_degenerate = st_reg[NS-1].degenerate;
        for (int k = 0; k < 3; k++)
        begin
            if (!st_reg[NS-1].kind)
                out_vec[k] = st_reg[NS-1].pos[k];
            else if (st_reg[NS-1].degenerate)
                out_vec[k] = '0;
            else if (st_reg[NS-1].neg[k])
                out_vec[k] = 32'd0 - 32'(st_reg[NS-1].q[k]);
            else
                out_vec[k] = 32'(st_reg[NS-1].q[k]);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vertex_position_normal_transform.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Affine vertex/normal transform. One beat in and one out per cycle at full
// rate; every beat passes the same stages (products, row sums, magnitude
// alignment, then a 31-stage square root and 17-stage divider). Positions ride
// the same pipe so order is kept. A stall on a valid output freezes the whole pipe.
module vertex_position_normal_transform (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [31:0] vec_x,
    input  wire logic [31:0] vec_y,
    input  wire logic [31:0] vec_z,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [31:0]      out_x,
    output logic [31:0]      out_y,
    output logic [31:0]      out_z,
    output logic             degenerate
);
    import vpnt_pkg::*;

    row_t        aff_reg [3];
    row_t        nrm_reg [3];
    logic [63:0] off_xy_reg;
    logic [31:0] off_z_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aff_reg[0] <= 48'd4096;
            aff_reg[1] <= 48'd4096 << 16;
            aff_reg[2] <= 48'd4096 << 32;
            nrm_reg[0] <= 48'd4096;
            nrm_reg[1] <= 48'd4096 << 16;
            nrm_reg[2] <= 48'd4096 << 32;
            off_xy_reg <= '0;
            off_z_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_AFF_X:  aff_reg[0] <= cfg_data[47:0];
                REG_AFF_Y:  aff_reg[1] <= cfg_data[47:0];
                REG_AFF_Z:  aff_reg[2] <= cfg_data[47:0];
                REG_OFF_XY: off_xy_reg <= cfg_data;
                REG_OFF_Z:  off_z_reg  <= cfg_data[31:0];
                REG_NRM_X:  nrm_reg[0] <= cfg_data[47:0];
                REG_NRM_Y:  nrm_reg[1] <= cfg_data[47:0];
                REG_NRM_Z:  nrm_reg[2] <= cfg_data[47:0];
                default:    ;
            endcase
        end
    end

    logic advance;
    logic st_valid;
    assign advance  = !(st_valid && out_stall);
    assign in_stall = !advance;

    // stage A: input capture
    logic                 a_valid_reg, a_kind_reg;
    logic signed [31:0]   a_vec_reg [3];
    // stage B: nine products
    logic                 b_valid_reg, b_kind_reg;
    logic signed [ProdW-1:0] b_prod_reg [3][3];
    // stage C: row sums
    logic                 c_valid_reg, c_kind_reg;
    logic signed [DotW-1:0] c_dot_reg [3];
    // stage D: sign/magnitude, position rounding
    logic                 d_valid_reg, d_kind_reg, d_zero_reg;
    logic [2:0]           d_neg_reg;
    logic [DotW-1:0]      d_mag_reg [3];
    logic [5:0]           d_lz_reg;
    // stage E: aligned magnitudes
    norm_in_t             e_reg;

    logic signed [DotW-1:0] pos_q [3];

    always_comb
    begin
        logic signed [DotW+1:0] t;
        logic signed [DotW+1:0] r;
        for (int k = 0; k < 3; k++)
        begin
            t = (DotW+2)'(c_dot_reg[k]) + (DotW+2)'(2048);
            r = t >>> 12;
            if (r > (DotW+2)'(64'sd2147483647))
                pos_q[k] = DotW'(64'sd2147483647);
            else if (r < -(DotW+2)'(64'sd2147483648))
                pos_q[k] = -DotW'(64'sd2147483648);
            else
                pos_q[k] = DotW'(r);
        end
    end

    logic [DotW-1:0] mx;
    logic [5:0]      lz;
    always_comb
    begin
        logic [DotW-1:0] m [3];
        for (int k = 0; k < 3; k++)
        begin
            m[k] = c_dot_reg[k][DotW-1] ? DotW'(-c_dot_reg[k]) : DotW'(c_dot_reg[k]);
        end
        mx = m[0] | m[1] | m[2];
        lz = 6'd0;
        for (int b = 0; b < DotW; b++)
        begin
            if (mx[b])
                lz = 6'(b);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_reg       <= '0;
        end
        else if (advance)
        begin
            a_valid_reg  <= in_valid;
            a_kind_reg   <= func;
            a_vec_reg[0] <= vec_x;
            a_vec_reg[1] <= vec_y;
            a_vec_reg[2] <= vec_z;

            b_valid_reg <= a_valid_reg;
            b_kind_reg  <= a_kind_reg;
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    b_prod_reg[r][k] <= ProdW'($signed(a_kind_reg ? nrm_reg[r][16*k +: 16]
                                                                  : aff_reg[r][16*k +: 16]))
                                      * ProdW'(a_vec_reg[k]);
                end
            end

            c_valid_reg <= b_valid_reg;
            c_kind_reg  <= b_kind_reg;
            c_dot_reg[0] <= DotW'(b_prod_reg[0][0]) + DotW'(b_prod_reg[0][1])
                          + DotW'(b_prod_reg[0][2])
                          + (b_kind_reg ? '0 : DotW'($signed(off_xy_reg[31:0])) <<< 12);
            c_dot_reg[1] <= DotW'(b_prod_reg[1][0]) + DotW'(b_prod_reg[1][1])
                          + DotW'(b_prod_reg[1][2])
                          + (b_kind_reg ? '0 : DotW'($signed(off_xy_reg[63:32])) <<< 12);
            c_dot_reg[2] <= DotW'(b_prod_reg[2][0]) + DotW'(b_prod_reg[2][1])
                          + DotW'(b_prod_reg[2][2])
                          + (b_kind_reg ? '0 : DotW'($signed(off_z_reg)) <<< 12);

            d_valid_reg <= c_valid_reg;
            d_kind_reg  <= c_kind_reg;
            d_zero_reg  <= (mx == '0);
            d_lz_reg    <= lz;
            for (int k = 0; k < 3; k++)
            begin
                d_neg_reg[k] <= c_dot_reg[k][DotW-1];
                d_mag_reg[k] <= c_kind_reg
                    ? (c_dot_reg[k][DotW-1] ? DotW'(-c_dot_reg[k]) : DotW'(c_dot_reg[k]))
                    : pos_q[k];
            end

            e_reg.valid      <= d_valid_reg;
            e_reg.kind       <= d_kind_reg;
            e_reg.degenerate <= d_kind_reg && d_zero_reg;
            e_reg.neg        <= d_neg_reg;
            for (int k = 0; k < 3; k++)
            begin
                e_reg.pos[k] <= d_mag_reg[k];
                if (d_lz_reg >= 6'd29)
                    e_reg.mag[k] <= MagW'(d_mag_reg[k] >> (d_lz_reg - 6'd29));
                else
                    e_reg.mag[k] <= MagW'(d_mag_reg[k] << (6'd29 - d_lz_reg));
            end
        end
    end

    logic [2:0][31:0] vec_o;

    vpnt_stage u_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .din            (e_reg),
        .out_valid      (st_valid),
        .out_kind       (kind),
        .out_degenerate (degenerate),
        .out_vec        (vec_o)
    );

    assign out_valid = st_valid;
    assign out_x = vec_o[0];
    assign out_y = vec_o[1];
    assign out_z = vec_o[2];

endmodule

`default_nettype wire

// ===== rtl/vpnt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vpnt_sva (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        kind,
    input wire logic [31:0] out_x,
    input wire logic        degenerate
);
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall)) else $error("input stall without output stall");
    a_pos_nondeg: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !kind) |-> !degenerate) else $error("position flagged degenerate");
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |-> (out_x == 32'd0)) else $error("degenerate nonzero");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_x))) else $error("lost beat");
endmodule

bind vertex_position_normal_transform vpnt_sva u_vpnt_sva (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
    .out_stall(out_stall), .kind(kind), .out_x(out_x), .degenerate(degenerate)
);

`default_nettype wire

// ===== bench/vpnt_checker.sv =====
`timescale 1ns / 1ps

module vpnt_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic        func,
    input  wire logic [31:0] vec_x,
    input  wire logic [31:0] vec_y,
    input  wire logic [31:0] vec_z,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic        kind,
    input  wire logic [31:0] out_x,
    input  wire logic [31:0] out_y,
    input  wire logic [31:0] out_z,
    input  wire logic        degenerate,
    output int               errors,
    output int               pending
);
    import vpnt_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        degenerate;
    } vtx_result_t;

    row_t        aff_row [3];
    row_t        nrm_row [3];
    logic [63:0] off_xy;
    logic [31:0] off_z;

    vtx_result_t expected_vtx [$];

    function automatic longint row_dot(input row_t row, input longint v [3]);
        longint acc;
        acc = 0;
        for (int k = 0; k < 3; k++)
            acc += longint'($signed(row[16*k +: 16])) * v[k];
        return acc;
    endfunction

    function automatic logic [31:0] round_sat(input longint t);
        longint r;
        r = (t + 2048) >>> 12;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic vtx_result_t transform_vertex(input logic f, input logic [31:0] vx,
                                                     input logic [31:0] vy,
                                                     input logic [31:0] vz);
        vtx_result_t r;
        longint v [3];
        longint off [3];
        longint n;
        longint unsigned mag [3];
        logic neg [3];
        longint unsigned mx, sq, len, q;
        logic [31:0] o [3];
        v[0] = longint'($signed(vx));
        v[1] = longint'($signed(vy));
        v[2] = longint'($signed(vz));
        r = '0;
        r.kind = f;
        if (!f)
        begin
            off[0] = longint'($signed(off_xy[31:0]));
            off[1] = longint'($signed(off_xy[63:32]));
            off[2] = longint'($signed(off_z));
            r.x = round_sat(row_dot(aff_row[0], v) + off[0] * 4096);
            r.y = round_sat(row_dot(aff_row[1], v) + off[1] * 4096);
            r.z = round_sat(row_dot(aff_row[2], v) + off[2] * 4096);
            return r;
        end
        mx = 0;
        for (int k = 0; k < 3; k++)
        begin
            n = row_dot(nrm_row[k], v);
            neg[k] = n < 0;
            mag[k] = neg[k] ? -n : n;
            if (mag[k] > mx)
                mx = mag[k];
        end
        if (mx == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        while (mx >= (64'd1 << 30))
        begin
            mx >>= 1;
            for (int k = 0; k < 3; k++)
                mag[k] >>= 1;
        end
        while (mx < (64'd1 << 29))
        begin
            mx <<= 1;
            for (int k = 0; k < 3; k++)
                mag[k] <<= 1;
        end
        sq = 0;
        for (int k = 0; k < 3; k++)
            sq += mag[k] * mag[k];
        len = int_sqrt(sq);
        for (int k = 0; k < 3; k++)
        begin
            q = ((mag[k] << 16) + (len >> 1)) / len;
            o[k] = neg[k] ? 32'(-q) : q[31:0];
        end
        r.x = o[0];
        r.y = o[1];
        r.z = o[2];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vtx_result_t got, want;
        if (!rst_n)
        begin
            aff_row[0] = 48'd4096;
            aff_row[1] = 48'd4096 << 16;
            aff_row[2] = 48'd4096 << 32;
            nrm_row[0] = 48'd4096;
            nrm_row[1] = 48'd4096 << 16;
            nrm_row[2] = 48'd4096 << 32;
            off_xy = '0;
            off_z = '0;
            errors = 0;
            expected_vtx.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{kind, out_x, out_y, out_z, degenerate};
                if (expected_vtx.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected beat: %p", got);
                end
                else
                begin
                    want = expected_vtx.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_vtx.insert(expected_vtx.size(),
                                    transform_vertex(func, vec_x, vec_y, vec_z));
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    REG_AFF_X:  aff_row[0] = cfg_data[47:0];
                    REG_AFF_Y:  aff_row[1] = cfg_data[47:0];
                    REG_AFF_Z:  aff_row[2] = cfg_data[47:0];
                    REG_OFF_XY: off_xy = cfg_data;
                    REG_OFF_Z:  off_z = cfg_data[31:0];
                    REG_NRM_X:  nrm_row[0] = cfg_data[47:0];
                    REG_NRM_Y:  nrm_row[1] = cfg_data[47:0];
                    REG_NRM_Z:  nrm_row[2] = cfg_data[47:0];
                    default: ;
                endcase
            pending = expected_vtx.size();
        end
    end

endmodule

// ===== bench/tb_vertex_position_normal_transform.sv =====
`timescale 1ns / 1ps

module tb_vertex_position_normal_transform;
    import vpnt_pkg::*;

    localparam int IdleLimit = 5000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [31:0] vec_x, vec_y, vec_z;
    logic        out_valid;
    logic        out_stall;
    logic        kind;
    logic [31:0] out_x, out_y, out_z;
    logic        degenerate;
    int          errors;
    int          pending;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    bit hold_req;
    bit hold_taken;
    int idle_count;

    vertex_position_normal_transform dut (.*);

    vpnt_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_cycles <= 300;
            out_stall <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= $urandom_range(99) < recv_stall_pct;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IdleLimit)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] rand_coef;
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom);
            default: return 16'($signed(14'($urandom)));
        endcase
    endfunction

    function automatic logic [47:0] rand_row;
        return {rand_coef(), rand_coef(), rand_coef()};
    endfunction

    function automatic logic [31:0] rand_comp;
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'($signed(20'($urandom)));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_vertex(input logic f, input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        vec_x <= x;
        vec_y <= y;
        vec_z <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic set_config(input int setting);
        logic [47:0] rows [6];
        logic [63:0] oxy;
        logic [31:0] oz;
        for (int k = 0; k < 6; k++)
            rows[k] = rand_row();
        oxy = {$urandom, $urandom};
        oz = $urandom;
        case (setting)
            0:
            begin
                rows = '{48'h0000_0000_7FFF, 48'h0000_7FFF_0000, 48'h7FFF_0000_0000,
                         48'h0, 48'h0, 48'h0};
                oxy = 64'h7FFF_FFFF_8000_0000;
                oz = 32'h7FFF_FFFF;
            end
            1:
            begin
                rows = '{48'h8000_8000_8000, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF,
                         48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h8000_7FFF_8000};
                oxy = 64'h8000_0000_7FFF_FFFF;
                oz = 32'h8000_0000;
            end
            2:
            begin
                rows = '{48'h0000_0000_1000, 48'h0000_1000_0000, 48'h1000_0000_0000,
                         48'h0000_0000_0001, 48'h0000_0001_0000, 48'h0001_0000_0000};
                oxy = 64'h0;
                oz = 32'h0;
            end
            default: ;
        endcase
        for (int k = 0; k < 3; k++)
            write_reg(REG_AFF_X + 3'(k), {16'($urandom), rows[k]});
        write_reg(REG_OFF_XY, oxy);
        write_reg(REG_OFF_Z, {32'($urandom), oz});
        for (int k = 0; k < 3; k++)
            write_reg(REG_NRM_X + 3'(k), {16'($urandom), rows[3 + k]});
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        func <= 1'b0;
        vec_x <= '0;
        vec_y <= '0;
        vec_z <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset matrices: extremes, zero normal, both kinds
        for (int f = 0; f < 2; f++)
        begin
            send_vertex(f, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            send_vertex(f, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            send_vertex(f, 32'h0, 32'h0, 32'h0);
            send_vertex(f, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0);
            send_vertex(f, 32'h0001_0000, 32'h0, 32'h0);
            send_vertex(f, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000);
        end
        in_valid <= 1'b0;
        drain();
        set_config(0);
        for (int f = 0; f < 2; f++)
        begin
            send_vertex(f, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            send_vertex(f, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            send_vertex(f, 32'h0000_8000, 32'hFFFF_8000, 32'h0);
        end
        in_valid <= 1'b0;
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            set_config(phase % 5 == 4 ? 3 : phase % 4);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            if (phase == 0)
                hold_req = 1'b1;
            for (int i = 0; i < 200; i++)
            begin
                if (phase == 5 && i == 100)
                begin
                    in_valid <= 1'b0;
                    drain();
                end
                send_vertex($urandom_range(1), rand_comp(), rand_comp(), rand_comp());
            end
            in_valid <= 1'b0;
            drain();
        end

        repeat (80) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/vpnt_pkg.sv
rtl/vpnt_stage.sv
rtl/vertex_position_normal_transform.sv
rtl/vpnt_checker.sv
bench/vpnt_checker.sv
bench/tb_vertex_position_normal_transform.sv
